[sv/bounded_utf8_validator_macros.svh]
// ----------------------------------------------------------------------------
// bounded_utf8_validator_macros.svh
// Assertion macros shared by the validator's checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UTF8_VALIDATOR_MACROS_SVH
`define BOUNDED_UTF8_VALIDATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BUV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BUV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/buv_pkg.sv]
// ----------------------------------------------------------------------------
// buv_pkg
// Types and byte constants for the bounded UTF-8 validator.
// ----------------------------------------------------------------------------
package buv_pkg;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_ACCEPT  = 2'd1,
    V_REJECT  = 2'd2
  } verdict_t;

  // Range check pending on the first continuation byte.
  typedef enum logic [2:0] {
    R_NONE = 3'd0,
    R_E0   = 3'd1,
    R_ED   = 3'd2,
    R_F0   = 3'd3,
    R_F4   = 3'd4
  } rule_t;

  typedef struct packed {
    logic [1:0] cont_left;
    rule_t      rule;
    verdict_t   verdict;
  } seq_state_t;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] E0_MIN     = 8'hA0;
  localparam logic [7:0] ED_MAX     = 8'h9F;
  localparam logic [7:0] F0_MIN     = 8'h90;
  localparam logic [7:0] F4_MAX     = 8'h8F;

endpackage

[sv/buv_decode.sv]
// ----------------------------------------------------------------------------
// buv_decode
// Next-state logic for one byte: lead/continuation decode, range rules,
// position limit and verdict.
// ----------------------------------------------------------------------------
module buv_decode import buv_pkg::*; #(
  parameter int MAX_BYTES = 256,
  parameter int POS_W     = 9
) (
  input  logic             start_req,
  input  logic [7:0]       data_byte,
  input  logic [POS_W-1:0] pos,
  input  seq_state_t       st,
  output logic [POS_W-1:0] pos_next,
  output seq_state_t       st_next
);

  localparam logic [POS_W:0] LIMIT = (POS_W+1)'(MAX_BYTES);

  logic [POS_W-1:0] cur_pos;
  seq_state_t       cur;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   seq_end;
  logic [1:0]       count;
  rule_t            lead_rule;
  logic             lead_ok;
  logic             bad;

  always_comb begin
    cur_pos = start_req ? '0 : pos;
    cur     = start_req ? seq_state_t'{cont_left: 2'd0, rule: R_NONE, verdict: V_PENDING}
                        : st;
    pos_inc = {1'b0, cur_pos} + (POS_W+1)'(1);
  end

  always_comb begin
    count     = 2'd0;
    lead_rule = R_NONE;
    lead_ok   = 1'b1;
    unique case (data_byte) inside
      [LEAD2_LO:LEAD2_HI]: count = 2'd1;
      [LEAD3_LO:LEAD3_HI]: begin
        count = 2'd2;
        if (data_byte == LEAD3_LO) lead_rule = R_E0;
        if (data_byte == LEAD3_SURR) lead_rule = R_ED;
      end
      [LEAD4_LO:LEAD4_HI]: begin
        count = 2'd3;
        if (data_byte == LEAD4_LO) lead_rule = R_F0;
        if (data_byte == LEAD4_HI) lead_rule = R_F4;
      end
      default: lead_ok = 1'b0;
    endcase
    seq_end = {1'b0, cur_pos} + (POS_W+1)'(count);
  end

  always_comb begin
    bad = (data_byte & CONT_MASK) != CONT_TAG;
    unique case (cur.rule)
      R_E0:    if (data_byte < E0_MIN) bad = 1'b1;
      R_ED:    if (data_byte > ED_MAX) bad = 1'b1;
      R_F0:    if (data_byte < F0_MIN) bad = 1'b1;
      R_F4:    if (data_byte > F4_MAX) bad = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    st_next  = cur;
    pos_next = cur_pos;
    if (cur.verdict == V_PENDING) begin
      if (cur.cont_left != 2'd0) begin
        if (bad) begin
          st_next.verdict = V_REJECT;
        end else begin
          st_next.rule      = R_NONE;
          st_next.cont_left = cur.cont_left - 2'd1;
          pos_next          = pos_inc[POS_W-1:0];
          if (pos_inc >= LIMIT) st_next.verdict = V_REJECT;
        end
      end else if (data_byte == 8'h00) begin
        st_next.verdict = (cur_pos == '0) ? V_REJECT : V_ACCEPT;
      end else if (data_byte <= ASCII_MAX) begin
        pos_next = pos_inc[POS_W-1:0];
        if (pos_inc >= LIMIT) st_next.verdict = V_REJECT;
      end else if (!lead_ok || seq_end >= LIMIT) begin
        st_next.verdict = V_REJECT;
      end else begin
        st_next.cont_left = count;
        st_next.rule      = lead_rule;
        pos_next          = pos_inc[POS_W-1:0];
        if (pos_inc >= LIMIT) st_next.verdict = V_REJECT;
      end
    end
  end

endmodule

[sv/bounded_utf8_validator.sv]
// ----------------------------------------------------------------------------
// bounded_utf8_validator
// Streaming strict UTF-8 check of a zero-terminated string, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted request carries one byte and yields one verdict (0 pending,
// 1 accepted, 2 rejected), sticky until a request with start_req set. The
// byte is decoded and the string state updated in the cycle it is accepted;
// its verdict goes to the output register, or to a skid register that holds
// one verdict when the output is stalled. Throughput is one byte per cycle
// while in_stall is low; in_stall rises only while that skid register is
// occupied. Strings must end within MAX_BYTES.
module bounded_utf8_validator import buv_pkg::*; #(
  parameter int MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       start_req,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] verdict
);

  localparam int POS_W = $clog2(MAX_BYTES + 1);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  seq_state_t       st;
  seq_state_t       st_next;
  logic             skid_valid;
  logic [1:0]       skid_verdict;
  logic             accept;
  logic             out_free;

  buv_decode #(
    .MAX_BYTES (MAX_BYTES),
    .POS_W     (POS_W)
  ) u_decode (
    .start_req (start_req),
    .data_byte (data_byte),
    .pos       (pos),
    .st        (st),
    .pos_next  (pos_next),
    .st_next   (st_next)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      st  <= '{cont_left: 2'd0, rule: R_NONE, verdict: V_PENDING};
    end else if (accept) begin
      pos <= pos_next;
      st  <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        verdict <= skid_verdict;
      end else if (accept) begin
        verdict <= st_next.verdict;
      end
    end else if (accept) begin
      skid_verdict <= st_next.verdict;
    end
  end

endmodule

[sv/buv_checker.sv]
// ----------------------------------------------------------------------------
// buv_checker
// Port-level checks for the validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_utf8_validator_macros.svh"

module buv_checker import buv_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       start_req,
  input logic [7:0] data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] verdict
);

  logic req_fast;

  // start request accepted while the output slot is free: verdict shows next cycle
  assign req_fast = in_valid && !in_stall && start_req && (!out_valid || !out_stall);

  `BUV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "verdict dropped while stalled")
  `BUV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(verdict), "verdict changed while stalled")
  `BUV_ASSERT_NEXT(a_empty_reject, req_fast && data_byte == 8'h00, out_valid && verdict == V_REJECT, "empty string not rejected")
  `BUV_ASSERT_NEXT(a_ascii_pending, req_fast && data_byte != 8'h00 && data_byte <= ASCII_MAX, out_valid && verdict == V_PENDING, "ASCII first byte not pending")

endmodule

bind bounded_utf8_validator buv_checker u_buv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .start_req (start_req),
  .data_byte (data_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict)
);

[test/tb_bounded_utf8_validator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_utf8_validator
// Self-checking bench for the streaming strict UTF-8 string validator.
// ----------------------------------------------------------------------------
// A short directed table covers the following:
//   - the first string after reset, which has no start flag
//   - the empty string
//   - bytes after a verdict
//   - every lead class and each second-byte range rule
//   - a terminator inside a sequence
//   - a bad lead byte
// Random strings follow. Most are well formed, some are broken, some are
// noise. A few long strings run into the byte limit.
// Every accepted request is run through a local string decoder. Each verdict
// that the block returns is compared in order. Both handshakes idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_bounded_utf8_validator;
  import buv_pkg::*;

  localparam int MAX_BYTES   = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 450;
  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       typed;
    verdict_t   want;
    logic       drain;
  } byte_req_t;

  localparam dir_row_t DIRECTED [0:26] = '{
    '{1'b0, 8'h41, 1'b1, V_PENDING},  // no start after reset
    '{1'b0, 8'h00, 1'b1, V_ACCEPT},
    '{1'b0, 8'hFF, 1'b1, V_ACCEPT},   // ignored after verdict
    '{1'b1, 8'h00, 1'b1, V_REJECT},   // empty string
    '{1'b1, 8'h7F, 1'b1, V_PENDING},
    '{1'b0, 8'hDF, 1'b0, V_PENDING},
    '{1'b0, 8'hBF, 1'b0, V_PENDING},
    '{1'b0, 8'hE0, 1'b0, V_PENDING},
    '{1'b0, 8'hA0, 1'b0, V_PENDING},
    '{1'b0, 8'h80, 1'b0, V_PENDING},
    '{1'b0, 8'hED, 1'b0, V_PENDING},
    '{1'b0, 8'h9F, 1'b0, V_PENDING},
    '{1'b0, 8'hBF, 1'b0, V_PENDING},
    '{1'b0, 8'hF0, 1'b0, V_PENDING},
    '{1'b0, 8'h90, 1'b0, V_PENDING},
    '{1'b0, 8'h80, 1'b0, V_PENDING},
    '{1'b0, 8'h80, 1'b0, V_PENDING},
    '{1'b0, 8'hF4, 1'b0, V_PENDING},
    '{1'b0, 8'h8F, 1'b0, V_PENDING},
    '{1'b0, 8'hBF, 1'b0, V_PENDING},
    '{1'b0, 8'hBF, 1'b0, V_PENDING},
    '{1'b0, 8'h00, 1'b1, V_ACCEPT},
    '{1'b1, 8'hE0, 1'b0, V_PENDING},
    '{1'b0, 8'h9F, 1'b1, V_REJECT},   // overlong after E0
    '{1'b1, 8'hC2, 1'b0, V_PENDING},
    '{1'b0, 8'h00, 1'b1, V_REJECT},   // terminator inside sequence
    '{1'b1, 8'hF5, 1'b1, V_REJECT}    // bad lead
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       start_req = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] verdict;

  logic       req_typed = 1'b0;
  verdict_t   req_want = V_PENDING;

  byte_req_t  stim_q[$];
  verdict_t   verdict_q[$];
  verdict_t   pred_v;
  verdict_t   want_v;
  int         err_count = 0;
  int         cycle_count = 0;
  bit         fresh_string = 1'b1;
  bit         drain_next = 1'b0;

  // decoder state for the string in flight
  int         str_pos;
  logic [1:0] cont_left;
  rule_t      pend_rule;
  verdict_t   str_verdict;

  int         stall_mode = 0;
  int         mode_left = 0;

  bounded_utf8_validator #(.MAX_BYTES(MAX_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (start_req),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic clear_string();
    str_pos     = 0;
    cont_left   = 2'd0;
    pend_rule   = R_NONE;
    str_verdict = V_PENDING;
  endtask

  task automatic step_pos();
    str_pos++;
    if (str_pos >= MAX_BYTES) str_verdict = V_REJECT;
  endtask

  task automatic decode_byte(input logic start, input logic [7:0] b, output verdict_t v);
    logic  bad;
    int    need;
    rule_t r;
    if (start) clear_string();
    if (str_verdict == V_PENDING) begin
      if (cont_left != 2'd0) begin
        bad = (b & CONT_MASK) != CONT_TAG;
        case (pend_rule)
          R_E0: if (b < E0_MIN) bad = 1'b1;
          R_ED: if (b > ED_MAX) bad = 1'b1;
          R_F0: if (b < F0_MIN) bad = 1'b1;
          R_F4: if (b > F4_MAX) bad = 1'b1;
          default: ;
        endcase
        if (bad) begin
          str_verdict = V_REJECT;
        end else begin
          pend_rule = R_NONE;
          cont_left--;
          step_pos();
        end
      end else if (b == TERMINATOR) begin
        str_verdict = (str_pos == 0) ? V_REJECT : V_ACCEPT;
      end else if (b <= ASCII_MAX) begin
        step_pos();
      end else begin
        need = 0;
        r    = R_NONE;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          need = 1;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          need = 2;
          if (b == LEAD3_LO) r = R_E0;
          if (b == LEAD3_SURR) r = R_ED;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          need = 3;
          if (b == LEAD4_LO) r = R_F0;
          if (b == LEAD4_HI) r = R_F4;
        end
        if (need == 0 || str_pos + need >= MAX_BYTES) begin
          str_verdict = V_REJECT;
        end else begin
          cont_left = need[1:0];
          pend_rule = r;
          step_pos();
        end
      end
    end
    v = str_verdict;
  endtask

  // ---- stimulus generation ----
  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stim_q.push_back('{fresh_string, b, 1'b0, V_PENDING, drain_next});
    fresh_string = 1'b0;
    drain_next   = 1'b0;
  endtask

  task automatic push_good_char();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: push_byte(8'($urandom_range(1, 127)));
      1: begin
        push_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
        push_byte(cont_byte());
      end
      2: begin
        lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        if ($urandom_range(0, 2) == 0) lead = $urandom_range(0, 1) ? LEAD3_LO : LEAD3_SURR;
        push_byte(lead);
        if (lead == LEAD3_LO) push_byte(8'($urandom_range(E0_MIN, 8'hBF)));
        else if (lead == LEAD3_SURR) push_byte(8'($urandom_range(8'h80, ED_MAX)));
        else push_byte(cont_byte());
        push_byte(cont_byte());
      end
      default: begin
        lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        push_byte(lead);
        if (lead == LEAD4_LO) push_byte(8'($urandom_range(F0_MIN, 8'hBF)));
        else if (lead == LEAD4_HI) push_byte(8'($urandom_range(8'h80, F4_MAX)));
        else push_byte(cont_byte());
        push_byte(cont_byte());
        push_byte(cont_byte());
      end
    endcase
  endtask

  task automatic push_bad_char();
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1)) push_byte(8'($urandom_range(8'h80, 8'hC1)));
        else push_byte(8'($urandom_range(8'hF5, 8'hFF)));
      end
      1: begin
        case ($urandom_range(0, 3))
          0: begin
            push_byte(LEAD3_LO);
            push_byte(8'($urandom_range(8'h80, 8'h9F)));
          end
          1: begin
            push_byte(LEAD3_SURR);
            push_byte(8'($urandom_range(8'hA0, 8'hBF)));
          end
          2: begin
            push_byte(LEAD4_LO);
            push_byte(8'($urandom_range(8'h80, 8'h8F)));
          end
          default: begin
            push_byte(LEAD4_HI);
            push_byte(8'($urandom_range(8'h90, 8'hBF)));
          end
        endcase
      end
      2: begin
        push_byte(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
        if ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 127)));
        else push_byte(8'($urandom_range(8'hC0, 8'hFF)));
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          push_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
        end else begin
          push_byte(8'($urandom_range(8'hE1, 8'hEC)));
          push_byte(cont_byte());
        end
        push_byte(TERMINATOR);
      end
    endcase
  endtask

  task automatic push_string(input bit long_str);
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    fresh_string = 1'b1;
    if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
    if (long_str) begin
      n = $urandom_range(250, 256);
      repeat (n) push_byte(8'($urandom_range(1, 127)));
      if ($urandom_range(0, 1)) push_good_char();
      push_byte(TERMINATOR);
    end else if (kind < 70) begin
      repeat ($urandom_range(0, 10)) push_good_char();
      push_byte(TERMINATOR);
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 5)) push_good_char();
      push_bad_char();
    end else begin
      repeat ($urandom_range(1, 8)) begin
        fresh_string = ($urandom_range(0, 7) == 0);
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // ---- request side: prediction at acceptance ----
  always @(posedge clk) begin
    if (rst) begin
      clear_string();
    end else if (in_valid && !in_stall) begin
      decode_byte(start_req, data_byte, pred_v);
      verdict_q.push_back(req_typed ? req_want : pred_v);
    end
  end

  // ---- result side: stall pattern and check ----
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(16, 128);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cycle_count % 8 < 5);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no request pending", verdict));
      end else begin
        want_v = verdict_q.pop_front();
        if (verdict !== want_v)
          report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want_v));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- main sequence ----
  initial begin
    int gap;
    int burst_left;
    int str_count;
    for (int i = 0; i < $size(DIRECTED); i++)
      stim_q.push_back('{DIRECTED[i].start, DIRECTED[i].data, DIRECTED[i].typed,
                         DIRECTED[i].want, 1'b0});
    drain_next = 1'b1;
    str_count  = 0;
    while (stim_q.size() < $size(DIRECTED) + RANDOM_REQS) begin
      if (str_count % 40 == 5) drain_next = 1'b1;
      push_string(str_count % 40 == 5);
      str_count++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    foreach (stim_q[i]) begin
      if (stim_q[i].drain || burst_left == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
        repeat (gap) @(posedge clk);
        if (stim_q[i].drain) while (verdict_q.size() != 0) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      in_valid  <= 1'b1;
      start_req <= stim_q[i].start;
      data_byte <= stim_q[i].data;
      req_typed <= stim_q[i].typed;
      req_want  <= stim_q[i].want;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
